>>> rtl/gcd_pkg.sv
// Shared constants, types and arithmetic helpers for the great-circle distance pipeline.
`default_nettype none

package gcd_pkg;

    localparam int ANGLE_FRAC_BITS = 20;
    localparam int WORK_DEG_BITS   = 28;
    localparam int WIDEN_SHIFT     = WORK_DEG_BITS - ANGLE_FRAC_BITS;

    localparam int LAT_W    = 28;
    localparam int LON_W    = 29;
    localparam int RADIUS_W = 23;
    localparam int DIST_W   = 25;

    localparam int DEG_W  = WORK_DEG_BITS + 12;
    localparam int REM_DW = WORK_DEG_BITS + 7;
    localparam int XY_W   = 34;
    localparam int Q30_W  = 32;
    localparam int RAD_W  = 61;
    localparam int ROOT_W = 62;
    localparam int ANG_W  = 32;
    localparam int PROD_W = ANG_W + RADIUS_W;

    localparam int CORDIC_STEPS = 30;
    localparam int SQRT_STEPS   = 31;
    localparam int STEP_W       = 5;
    localparam int LANES        = 3;

    localparam int PIPE_DEPTH = 4 + CORDIC_STEPS + 5 + SQRT_STEPS + 1 + CORDIC_STEPS + 3;

    localparam longint FULL_TURN    = 64'sd360 <<< WORK_DEG_BITS;
    localparam longint QUARTER_TURN = 64'sd90 <<< WORK_DEG_BITS;
    localparam longint DEG2RAD_Q32  = 64'sd74961321;
    localparam longint CORDIC_GAIN  = 64'sd652032874;
    localparam longint ONE_Q30      = 64'sd1 <<< 30;
    localparam longint HALF_PI_Q30  = 64'sd1686629713;
    localparam longint PI_Q30       = 64'sd3373259426;
    localparam longint MAX_DIST     = 64'sd26353589;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(6378170);

    typedef logic signed [DEG_W-1:0]  deg_t;
    typedef logic signed [XY_W-1:0]   xy_t;
    typedef logic signed [Q30_W-1:0]  q30_t;
    typedef logic [RAD_W-1:0]         rad_t;
    typedef logic [ROOT_W-1:0]        root_t;
    typedef logic [STEP_W-1:0]        step_t;
    typedef logic [1:0]               quad_t;

    function automatic xy_t atan_q30(input step_t i);
        logic [31:0] v;
        unique case (i)
            5'd0:  v = 32'h3243F6A8;
            5'd1:  v = 32'h1DAC6705;
            5'd2:  v = 32'h0FADBAFC;
            5'd3:  v = 32'h07F56EA6;
            5'd4:  v = 32'h03FEAB76;
            5'd5:  v = 32'h01FFD55B;
            5'd6:  v = 32'h00FFFAAA;
            5'd7:  v = 32'h007FFF55;
            5'd8:  v = 32'h003FFFEA;
            5'd9:  v = 32'h001FFFFD;
            5'd10: v = 32'h000FFFFF;
            5'd11: v = 32'h0007FFFF;
            5'd12: v = 32'h0003FFFF;
            5'd13: v = 32'h0001FFFF;
            5'd14: v = 32'h0000FFFF;
            5'd15: v = 32'h00007FFF;
            5'd16: v = 32'h00003FFF;
            5'd17: v = 32'h00001FFF;
            5'd18: v = 32'h00000FFF;
            5'd19: v = 32'h000007FF;
            5'd20: v = 32'h000003FF;
            5'd21: v = 32'h000001FF;
            5'd22: v = 32'h000000FF;
            5'd23: v = 32'h0000007F;
            5'd24: v = 32'h0000003F;
            5'd25: v = 32'h0000001F;
            5'd26: v = 32'h0000000F;
            5'd27: v = 32'h00000008;
            5'd28: v = 32'h00000004;
            5'd29: v = 32'h00000002;
            default: v = 32'h00000000;
        endcase
        return xy_t'({2'b00, v});
    endfunction

    function automatic q30_t sat_q30(input xy_t v);
        q30_t r;
        if (v > xy_t'(ONE_Q30)) begin
            r = q30_t'(ONE_Q30);
        end
        else if (v < -xy_t'(ONE_Q30)) begin
            r = -q30_t'(ONE_Q30);
        end
        else begin
            r = q30_t'(v);
        end
        return r;
    endfunction

    function automatic q30_t mul_q30(input q30_t a, input q30_t b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        p = (p + 64'sd536870912) >>> 30;
        return q30_t'(p[Q30_W-1:0]);
    endfunction

endpackage

`default_nettype wire

>>> rtl/gcd_rot_cell.sv
// One registered CORDIC rotation step that turns a vector toward a target angle.
`default_nettype none

module gcd_rot_cell
    import gcd_pkg::*;
(
    input  logic  clk,
    input  logic  en,
    input  step_t step,
    input  xy_t   x_in,
    input  xy_t   y_in,
    input  xy_t   z_in,
    input  quad_t quad_in,
    output xy_t   x_out,
    output xy_t   y_out,
    output xy_t   z_out,
    output quad_t quad_out
);

    xy_t   x_reg, y_reg, z_reg;
    xy_t   x_next, y_next, z_next;
    quad_t quad_reg;
    xy_t   xs, ys, at;

    always_comb
    begin
        xs = x_in >>> step;
        ys = y_in >>> step;
        at = atan_q30(step);
        if (!z_in[XY_W-1])
        begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - at;
        end
        else
        begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + at;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            quad_reg <= quad_in;
        end
    end

    assign x_out    = x_reg;
    assign y_out    = y_reg;
    assign z_out    = z_reg;
    assign quad_out = quad_reg;

endmodule

`default_nettype wire

>>> rtl/gcd_sqrt_cell.sv
// One registered step of the digit-by-digit integer square root.
`default_nettype none

module gcd_sqrt_cell
    import gcd_pkg::*;
(
    input  logic  clk,
    input  logic  en,
    input  step_t step,
    input  rad_t  v_in,
    input  root_t res_in,
    input  q30_t  c_in,
    output rad_t  v_out,
    output root_t res_out,
    output q30_t  c_out
);

    rad_t  v_reg, v_next;
    root_t res_reg, res_next;
    q30_t  c_reg;
    root_t bitv, sum;
    logic [6:0] sh;

    always_comb
    begin
        sh   = 7'(2 * (SQRT_STEPS - 1)) - {1'b0, step, 1'b0};
        bitv = ROOT_W'(1) << sh;
        sum  = res_in + bitv;
        if (ROOT_W'(v_in) >= sum)
        begin
            v_next   = v_in - RAD_W'(sum);
            res_next = (res_in >> 1) + bitv;
        end
        else
        begin
            v_next   = v_in;
            res_next = res_in >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg   <= v_next;
            res_reg <= res_next;
            c_reg   <= c_in;
        end
    end

    assign v_out   = v_reg;
    assign res_out = res_reg;
    assign c_out   = c_reg;

endmodule

`default_nettype wire

>>> rtl/gcd_vec_cell.sv
// One registered CORDIC vectoring step that drives y toward zero and sums the angle.
`default_nettype none

module gcd_vec_cell
    import gcd_pkg::*;
(
    input  logic  clk,
    input  logic  en,
    input  step_t step,
    input  xy_t   x_in,
    input  xy_t   y_in,
    input  xy_t   z_in,
    output xy_t   x_out,
    output xy_t   y_out,
    output xy_t   z_out
);

    xy_t x_reg, y_reg, z_reg;
    xy_t x_next, y_next, z_next;
    xy_t xs, ys, at;

    always_comb
    begin
        xs = x_in >>> step;
        ys = y_in >>> step;
        at = atan_q30(step);
        if (y_in > xy_t'(0))
        begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + at;
        end
        else
        begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - at;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

`default_nettype wire

>>> rtl/great_circle_distance_core.sv
// Top level of the great-circle distance pipeline.
// The core takes one item per cycle, while dist_stall does not hold it, through 104 register
// stages; the result is taken from dist_reg, the last stage. The depth is set by
// three chains of cells: 30 CORDIC rotation steps for the sines and cosines, 31 square root
// steps and 30 CORDIC vectoring steps for the arccosine, plus thirteen stages of angle
// reduction, products and scaling. The whole pipeline advances together and holds while a
// finished item waits under dist_stall. The radius register should be written only while the
// core holds no items.
`default_nettype none

module great_circle_distance_core
    import gcd_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       sphere_radius_we,
    input  logic [RADIUS_W-1:0]        sphere_radius_m,
    input  logic                       item_valid,
    output logic                       item_stall,
    input  logic signed [LAT_W-1:0]    lat_a,
    input  logic signed [LON_W-1:0]    lon_a,
    input  logic signed [LAT_W-1:0]    lat_b,
    input  logic signed [LON_W-1:0]    lon_b,
    output logic                       dist_valid,
    input  logic                       dist_stall,
    output logic [DIST_W-1:0]          distance_m
);

    logic                   en;
    logic [PIPE_DEPTH-1:0]  valid_reg;
    logic [RADIUS_W-1:0]    radius_reg;

    deg_t  deg_reg [LANES];
    deg_t  deg_next [LANES];
    deg_t  mod_reg [LANES];
    deg_t  mod_next [LANES];
    quad_t quad2_reg [LANES];
    quad_t quad2_next [LANES];
    logic [REM_DW-1:0] rdeg_reg [LANES];
    logic [REM_DW-1:0] rdeg_next [LANES];
    xy_t   z0_reg [LANES];
    xy_t   z0_next [LANES];
    quad_t quad3_reg [LANES];

    xy_t   rx [LANES][CORDIC_STEPS+1];
    xy_t   ry [LANES][CORDIC_STEPS+1];
    xy_t   rz [LANES][CORDIC_STEPS+1];
    quad_t rq [LANES][CORDIC_STEPS+1];

    q30_t  cs_reg [LANES];
    q30_t  sn_reg [LANES];
    q30_t  cs_next [LANES];
    q30_t  sn_next [LANES];

    q30_t  p1_reg, p2_reg, cd_reg, p1c_reg, p3_reg, c_reg;
    q30_t  c_next;
    rad_t  rem_next;

    rad_t  sv [SQRT_STEPS+1];
    root_t sr [SQRT_STEPS+1];
    q30_t  sc [SQRT_STEPS+1];

    xy_t   vx [CORDIC_STEPS+1];
    xy_t   vy [CORDIC_STEPS+1];
    xy_t   vz [CORDIC_STEPS+1];
    xy_t   vx0_next, vy0_next, vz0_next;
    xy_t   vx0_reg, vy0_reg, vz0_reg;

    logic [ANG_W-1:0]  ang_reg, ang_next;
    logic [PROD_W:0]   prod_reg;
    logic [DIST_W-1:0] dist_reg, dist_next;
    logic [PROD_W:0]   rnd;

    logic signed [LON_W:0] dlon;
    logic signed [63:0]    m1;
    logic [63:0]           zprod;
    logic signed [XY_W:0]  csum;

    assign en         = !valid_reg[PIPE_DEPTH-1] || !dist_stall;
    assign item_stall = !en;
    assign dist_valid = valid_reg[PIPE_DEPTH-1];
    assign distance_m = dist_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            radius_reg <= RADIUS_RESET;
        end
        else
        begin
            if (en)
            begin
                valid_reg <= {valid_reg[PIPE_DEPTH-2:0], item_valid};
            end
            if (sphere_radius_we)
            begin
                radius_reg <= sphere_radius_m;
            end
        end
    end

    always_comb
    begin
        dlon        = (LON_W+1)'(lon_b) - (LON_W+1)'(lon_a);
        deg_next[0] = DEG_W'(lat_a) <<< WIDEN_SHIFT;
        deg_next[1] = DEG_W'(lat_b) <<< WIDEN_SHIFT;
        deg_next[2] = DEG_W'(dlon) <<< WIDEN_SHIFT;
        m1 = '0;
        zprod = '0;
        for (int l = 0; l < LANES; l++)
        begin
            m1 = 64'(deg_reg[l]);
            if (m1 < 0)
            begin
                m1 = m1 + 2 * FULL_TURN;
            end
            if (m1 >= FULL_TURN)
            begin
                m1 = m1 - FULL_TURN;
            end
            mod_next[l] = DEG_W'(m1);

            if (64'(mod_reg[l]) >= 3 * QUARTER_TURN)
            begin
                quad2_next[l] = 2'd3;
                rdeg_next[l]  = REM_DW'(64'(mod_reg[l]) - 3 * QUARTER_TURN);
            end
            else if (64'(mod_reg[l]) >= 2 * QUARTER_TURN)
            begin
                quad2_next[l] = 2'd2;
                rdeg_next[l]  = REM_DW'(64'(mod_reg[l]) - 2 * QUARTER_TURN);
            end
            else if (64'(mod_reg[l]) >= QUARTER_TURN)
            begin
                quad2_next[l] = 2'd1;
                rdeg_next[l]  = REM_DW'(64'(mod_reg[l]) - QUARTER_TURN);
            end
            else
            begin
                quad2_next[l] = 2'd0;
                rdeg_next[l]  = REM_DW'(mod_reg[l]);
            end

            zprod      = 64'(rdeg_reg[l]) * 64'(DEG2RAD_Q32);
            zprod      = (zprod + (64'd1 << 29)) >> 30;
            z0_next[l] = xy_t'(zprod[XY_W-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                deg_reg[l]   <= deg_next[l];
                mod_reg[l]   <= mod_next[l];
                quad2_reg[l] <= quad2_next[l];
                rdeg_reg[l]  <= rdeg_next[l];
                z0_reg[l]    <= z0_next[l];
                quad3_reg[l] <= quad2_reg[l];
            end
        end
    end

    genvar gl, gk;
    generate
        for (gl = 0; gl < LANES; gl++)
        begin : g_lane
            assign rx[gl][0] = xy_t'(CORDIC_GAIN);
            assign ry[gl][0] = '0;
            assign rz[gl][0] = z0_reg[gl];
            assign rq[gl][0] = quad3_reg[gl];
            for (gk = 0; gk < CORDIC_STEPS; gk++)
            begin : g_rot
                gcd_rot_cell u_cell (
                    .clk      (clk),
                    .en       (en),
                    .step     (STEP_W'(gk)),
                    .x_in     (rx[gl][gk]),
                    .y_in     (ry[gl][gk]),
                    .z_in     (rz[gl][gk]),
                    .quad_in  (rq[gl][gk]),
                    .x_out    (rx[gl][gk+1]),
                    .y_out    (ry[gl][gk+1]),
                    .z_out    (rz[gl][gk+1]),
                    .quad_out (rq[gl][gk+1])
                );
            end
        end
    endgenerate

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            unique case (rq[l][CORDIC_STEPS])
                2'd0:
                begin
                    cs_next[l] = sat_q30(rx[l][CORDIC_STEPS]);
                    sn_next[l] = sat_q30(ry[l][CORDIC_STEPS]);
                end
                2'd1:
                begin
                    cs_next[l] = sat_q30(-ry[l][CORDIC_STEPS]);
                    sn_next[l] = sat_q30(rx[l][CORDIC_STEPS]);
                end
                2'd2:
                begin
                    cs_next[l] = sat_q30(-rx[l][CORDIC_STEPS]);
                    sn_next[l] = sat_q30(-ry[l][CORDIC_STEPS]);
                end
                default:
                begin
                    cs_next[l] = sat_q30(ry[l][CORDIC_STEPS]);
                    sn_next[l] = sat_q30(-rx[l][CORDIC_STEPS]);
                end
            endcase
        end
        csum     = (XY_W+1)'(p1c_reg) + (XY_W+1)'(p3_reg);
        c_next   = sat_q30(xy_t'(csum));
        rem_next = RAD_W'((64'd1 << 60) - 64'(64'(c_reg) * 64'(c_reg)));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                cs_reg[l] <= cs_next[l];
                sn_reg[l] <= sn_next[l];
            end
            p1_reg  <= mul_q30(sn_reg[0], sn_reg[1]);
            p2_reg  <= mul_q30(cs_reg[0], cs_reg[1]);
            cd_reg  <= cs_reg[2];
            p1c_reg <= p1_reg;
            p3_reg  <= mul_q30(p2_reg, cd_reg);
            c_reg   <= c_next;
        end
    end

    // The square root chain starts one stage after the saturated cosine sum.
    rad_t sq_v0_reg;
    q30_t sq_c0_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_v0_reg <= rem_next;
            sq_c0_reg <= c_reg;
        end
    end

    assign sv[0] = sq_v0_reg;
    assign sr[0] = '0;
    assign sc[0] = sq_c0_reg;

    generate
        for (gk = 0; gk < SQRT_STEPS; gk++)
        begin : g_sqrt
            gcd_sqrt_cell u_cell (
                .clk     (clk),
                .en      (en),
                .step    (STEP_W'(gk)),
                .v_in    (sv[gk]),
                .res_in  (sr[gk]),
                .c_in    (sc[gk]),
                .v_out   (sv[gk+1]),
                .res_out (sr[gk+1]),
                .c_out   (sc[gk+1])
            );
        end
    endgenerate

    always_comb
    begin
        if (sc[SQRT_STEPS][Q30_W-1])
        begin
            vx0_next = xy_t'(sr[SQRT_STEPS][31:0]);
            vy0_next = -xy_t'(sc[SQRT_STEPS]);
            vz0_next = xy_t'(HALF_PI_Q30);
        end
        else
        begin
            vx0_next = xy_t'(sc[SQRT_STEPS]);
            vy0_next = xy_t'(sr[SQRT_STEPS][31:0]);
            vz0_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vx0_reg <= vx0_next;
            vy0_reg <= vy0_next;
            vz0_reg <= vz0_next;
        end
    end

    assign vx[0] = vx0_reg;
    assign vy[0] = vy0_reg;
    assign vz[0] = vz0_reg;

    generate
        for (gk = 0; gk < CORDIC_STEPS; gk++)
        begin : g_vec
            gcd_vec_cell u_cell (
                .clk   (clk),
                .en    (en),
                .step  (STEP_W'(gk)),
                .x_in  (vx[gk]),
                .y_in  (vy[gk]),
                .z_in  (vz[gk]),
                .x_out (vx[gk+1]),
                .y_out (vy[gk+1]),
                .z_out (vz[gk+1])
            );
        end
    endgenerate

    always_comb
    begin
        if (vz[CORDIC_STEPS][XY_W-1])
        begin
            ang_next = '0;
        end
        else if (vz[CORDIC_STEPS] > xy_t'(PI_Q30))
        begin
            ang_next = ANG_W'(PI_Q30);
        end
        else
        begin
            ang_next = vz[CORDIC_STEPS][ANG_W-1:0];
        end
        rnd = (prod_reg + ((PROD_W+1)'(1) << 29)) >> 30;
        if (rnd > (PROD_W+1)'(MAX_DIST))
        begin
            dist_next = DIST_W'(MAX_DIST);
        end
        else
        begin
            dist_next = rnd[DIST_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ang_reg  <= ang_next;
            prod_reg <= (PROD_W+1)'(ang_reg) * (PROD_W+1)'(radius_reg);
            dist_reg <= dist_next;
        end
    end

endmodule

`default_nettype wire
